@@ src/scc_pkg.sv @@
// shared types, codes and the crc helper for the spi command sequencer
package scc_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUSY_CODE   = 3'd0,
    CFG_READY_CODE  = 3'd1,
    CFG_OPT_ACK     = 3'd2,
    CFG_NO_OPT      = 3'd3,
    CFG_RETRY_LIMIT = 3'd4,
    CFG_CRC_EN      = 3'd5
  } cfg_idx_t;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  localparam logic [1:0] WAIT_NONE   = 2'd0;
  localparam logic [1:0] WAIT_LONG   = 2'd1;
  localparam logic [1:0] WAIT_RETRY  = 2'd2;
  localparam logic [1:0] WAIT_SHORT  = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_RETRIES = 2'd1;
  localparam logic [1:0] STATUS_CRC     = 2'd2;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] BUSY_RST      = 8'd49;
  localparam logic [7:0] READY_RST     = 8'd243;
  localparam logic [7:0] OPT_ACK_RST   = 8'h03;
  localparam logic [7:0] NO_OPT_RST    = 8'd255;
  localparam logic [5:0] RETRY_RST     = 6'd20;
  localparam logic [5:0] RETRY_MAX     = 6'd62;
  localparam logic [5:0] RETRY_ALL1    = 6'd63;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_FIRST  = 5'b00010,
    PH_POLL   = 5'b00100,
    PH_OPTION = 5'b01000,
    PH_READ   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] cmd_code;
    logic [7:0] opt_code;
    logic [7:0] read_count;
    logic [7:0] reply_byte;
  } item_t;

  // one byte through crc-16/modbus, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

@@ src/scc_front.sv @@
// front end: accepts items, clamps the read count and queues them for the sequencer
module scc_front #(
  parameter int MAX_READ = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [7:0]         in_cmd_code,
  input  logic [7:0]         in_opt_code,
  input  logic [7:0]         in_read_count,
  input  logic [7:0]         in_reply_byte,
  output logic               q_valid,
  output scc_pkg::item_t     q_item,
  input  logic               q_pop
);
  import scc_pkg::*;

  localparam int          DEPTH     = 2;
  localparam logic [7:0]  MAX_READ_C = 8'(MAX_READ);

  item_t       entry_r [DEPTH];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  item_t       new_item;

  assign in_stall = (count_r == 2'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = entry_r[rd_ptr_r];

  always_comb begin
    new_item.kind         = in_kind;
    new_item.cmd_code     = in_cmd_code;
    new_item.opt_code     = in_opt_code;
    new_item.read_count   = (in_read_count > MAX_READ_C) ? MAX_READ_C : in_read_count;
    new_item.reply_byte   = in_reply_byte;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

@@ src/scc_seq.sv @@
// back end: transaction sequencer, configuration registers and result register
module scc_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  scc_pkg::item_t                 q_item,
  output logic                           q_pop,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [scc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_send_valid,
  output logic [7:0]                     out_send_byte,
  output logic [1:0]                     out_wait_kind,
  output logic                           out_data_valid,
  output logic [7:0]                     out_data_byte,
  output logic [7:0]                     out_data_index,
  output logic                           out_done_res,
  output logic [1:0]                     out_status,
  output logic                           out_busy_mismatch,
  output logic                           out_option_nack
);
  import scc_pkg::*;

  // configuration
  logic [7:0]  busy_code_r, ready_code_r, opt_ack_r, no_opt_r;
  logic [5:0]  retry_limit_r;
  logic        crc_en_r;

  // transaction state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  opt_r, opt_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  bytes_read_r, bytes_read_nxt;
  logic [5:0]  retries_r, retries_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] rx_sum_r, rx_sum_nxt;
  logic [1:0]  warn_r, warn_nxt;

  // result register
  logic        res_valid_r;
  logic        send_valid_r, send_valid_nxt;
  logic [7:0]  send_byte_r, send_byte_nxt;
  logic [1:0]  wait_kind_r, wait_kind_nxt;
  logic        data_valid_r, data_valid_nxt;
  logic [7:0]  data_byte_r, data_byte_nxt;
  logic [7:0]  data_index_r, data_index_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  status_r, status_nxt;

  logic        take;
  logic [5:0]  limit;
  logic [8:0]  br9, cnt9;
  logic        cnt_ge2;

  assign cfg_ready = 1'b1;
  assign take      = q_valid && (!res_valid_r || !out_stall);
  assign q_pop     = take;
  assign limit     = (retry_limit_r == RETRY_ALL1) ? RETRY_MAX : retry_limit_r;
  assign br9       = {1'b0, bytes_read_r};
  assign cnt9      = {1'b0, cnt_r};
  assign cnt_ge2   = (cnt_r >= 8'd2);

  always_comb begin
    phase_nxt      = phase_r;
    cmd_nxt        = cmd_r;
    opt_nxt        = opt_r;
    cnt_nxt        = cnt_r;
    bytes_read_nxt = bytes_read_r;
    retries_nxt    = retries_r;
    crc_nxt        = crc_r;
    rx_sum_nxt     = rx_sum_r;
    warn_nxt       = warn_r;
    send_valid_nxt = 1'b0;
    send_byte_nxt  = 8'd0;
    wait_kind_nxt  = WAIT_NONE;
    data_valid_nxt = 1'b0;
    data_byte_nxt  = 8'd0;
    data_index_nxt = 8'd0;
    done_nxt       = 1'b0;
    status_nxt     = STATUS_OK;

    if (q_item.kind == KIND_START) begin
      // a start always wins, even in the middle of a transaction
      cmd_nxt        = q_item.cmd_code;
      opt_nxt        = q_item.opt_code;
      cnt_nxt        = q_item.read_count;
      bytes_read_nxt = 8'd0;
      retries_nxt    = 6'd0;
      crc_nxt        = CRC_INIT;
      rx_sum_nxt     = 16'd0;
      warn_nxt       = 2'b00;
      send_valid_nxt = 1'b1;
      send_byte_nxt  = q_item.cmd_code;
      phase_nxt      = PH_FIRST;
    end else begin
      case (phase_r)
        PH_FIRST: begin
          if (q_item.reply_byte != busy_code_r) warn_nxt[0] = 1'b1;
          send_valid_nxt = 1'b1;
          send_byte_nxt  = cmd_r;
          wait_kind_nxt  = WAIT_LONG;
          phase_nxt      = PH_POLL;
        end
        PH_POLL: begin
          if (q_item.reply_byte == ready_code_r) begin
            if (opt_r != no_opt_r) begin
              send_valid_nxt = 1'b1;
              send_byte_nxt  = opt_r;
              wait_kind_nxt  = WAIT_SHORT;
              phase_nxt      = PH_OPTION;
            end else if (cnt_r != 8'd0) begin
              send_valid_nxt = 1'b1;
              send_byte_nxt  = cmd_r;
              wait_kind_nxt  = WAIT_SHORT;
              phase_nxt      = PH_READ;
            end else begin
              done_nxt      = 1'b1;
              wait_kind_nxt = WAIT_LONG;
              phase_nxt     = PH_IDLE;
            end
          end else if (retries_r > limit) begin
            done_nxt   = 1'b1;
            status_nxt = STATUS_RETRIES;
            phase_nxt  = PH_IDLE;
          end else begin
            retries_nxt    = retries_r + 6'd1;
            send_valid_nxt = 1'b1;
            send_byte_nxt  = cmd_r;
            wait_kind_nxt  = WAIT_RETRY;
          end
        end
        PH_OPTION: begin
          if (q_item.reply_byte != opt_ack_r) warn_nxt[1] = 1'b1;
          if (cnt_r != 8'd0) begin
            send_valid_nxt = 1'b1;
            send_byte_nxt  = cmd_r;
            phase_nxt      = PH_READ;
          end else begin
            done_nxt      = 1'b1;
            wait_kind_nxt = WAIT_LONG;
            phase_nxt     = PH_IDLE;
          end
        end
        PH_READ: begin
          data_valid_nxt = 1'b1;
          data_byte_nxt  = q_item.reply_byte;
          data_index_nxt = bytes_read_r;
          // last two bytes carry the checksum, low byte first
          if (cnt_ge2 && (br9 + 9'd2 == cnt9)) begin
            rx_sum_nxt = {rx_sum_r[15:8], q_item.reply_byte};
          end else if (cnt_ge2 && (br9 + 9'd1 == cnt9)) begin
            rx_sum_nxt = {q_item.reply_byte, rx_sum_r[7:0]};
          end else begin
            crc_nxt = crc_byte(crc_r, q_item.reply_byte);
          end
          bytes_read_nxt = bytes_read_r + 8'd1;
          if (bytes_read_nxt < cnt_r) begin
            send_valid_nxt = 1'b1;
            send_byte_nxt  = cmd_r;
          end else begin
            done_nxt      = 1'b1;
            wait_kind_nxt = WAIT_LONG;
            if (crc_en_r && cnt_ge2 && (rx_sum_nxt != crc_nxt)) status_nxt = STATUS_CRC;
            phase_nxt     = PH_IDLE;
          end
        end
        default: begin
          // reply while idle gives a flags-only result
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_code_r   <= BUSY_RST;
      ready_code_r  <= READY_RST;
      opt_ack_r     <= OPT_ACK_RST;
      no_opt_r      <= NO_OPT_RST;
      retry_limit_r <= RETRY_RST;
      crc_en_r      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BUSY_CODE:   busy_code_r   <= cfg_data;
        CFG_READY_CODE:  ready_code_r  <= cfg_data;
        CFG_OPT_ACK:     opt_ack_r     <= cfg_data;
        CFG_NO_OPT:      no_opt_r      <= cfg_data;
        CFG_RETRY_LIMIT: retry_limit_r <= cfg_data[5:0];
        CFG_CRC_EN:      crc_en_r      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      cmd_r        <= 8'd0;
      opt_r        <= 8'd0;
      cnt_r        <= 8'd0;
      bytes_read_r <= 8'd0;
      retries_r    <= 6'd0;
      crc_r        <= CRC_INIT;
      rx_sum_r     <= 16'd0;
      warn_r       <= 2'b00;
      res_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        phase_r      <= phase_nxt;
        cmd_r        <= cmd_nxt;
        opt_r        <= opt_nxt;
        cnt_r        <= cnt_nxt;
        bytes_read_r <= bytes_read_nxt;
        retries_r    <= retries_nxt;
        crc_r        <= crc_nxt;
        rx_sum_r     <= rx_sum_nxt;
        warn_r       <= warn_nxt;
        res_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        res_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      send_valid_r <= send_valid_nxt;
      send_byte_r  <= send_byte_nxt;
      wait_kind_r  <= wait_kind_nxt;
      data_valid_r <= data_valid_nxt;
      data_byte_r  <= data_byte_nxt;
      data_index_r <= data_index_nxt;
      done_r       <= done_nxt;
      status_r     <= status_nxt;
    end
  end

  assign out_valid         = res_valid_r;
  assign out_send_valid    = send_valid_r;
  assign out_send_byte     = send_byte_r;
  assign out_wait_kind     = wait_kind_r;
  assign out_data_valid    = data_valid_r;
  assign out_data_byte     = data_byte_r;
  assign out_data_index    = data_index_r;
  assign out_done_res      = done_r;
  assign out_status        = status_r;
  assign out_busy_mismatch = warn_r[0];
  assign out_option_nack   = warn_r[1];

endmodule

@@ src/spi_command_handshake_crc_check_top.sv @@
// top level of the spi command sequencer with poll handshake and crc-16 check
//
//   port group   dir   handshake          carries
//   in_*         in    in_valid/in_stall  start item or reply byte
//   out_*        out   out_valid/out_stall one result item per accepted item
//   cfg_*        in    cfg_valid/cfg_ready register index and write data
//
// one item per cycle sustained while out_stall does not hold the result; an item's
// result shows in the cycle after the sequencer takes it from the two-entry queue,
// with the sequencer step (crc update included) computed combinationally. the result
// register holds under out_stall while the queue keeps taking items until it is full.
// synchronous active-low reset clears the queue, state and result valid; config takes its defaults.
module spi_command_handshake_crc_check_top #(
  parameter int MAX_READ = 255
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [7:0]                     in_cmd_code,
  input  logic [7:0]                     in_opt_code,
  input  logic [7:0]                     in_read_count,
  input  logic [7:0]                     in_reply_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_send_valid,
  output logic [7:0]                     out_send_byte,
  output logic [1:0]                     out_wait_kind,
  output logic                           out_data_valid,
  output logic [7:0]                     out_data_byte,
  output logic [7:0]                     out_data_index,
  output logic                           out_done_res,
  output logic [1:0]                     out_status,
  output logic                           out_busy_mismatch,
  output logic                           out_option_nack,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [scc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data
);
  import scc_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  scc_front #(
    .MAX_READ(MAX_READ)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_cmd_code     (in_cmd_code),
    .in_opt_code     (in_opt_code),
    .in_read_count   (in_read_count),
    .in_reply_byte   (in_reply_byte),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  scc_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_send_valid    (out_send_valid),
    .out_send_byte     (out_send_byte),
    .out_wait_kind     (out_wait_kind),
    .out_data_valid    (out_data_valid),
    .out_data_byte     (out_data_byte),
    .out_data_index    (out_data_index),
    .out_done_res      (out_done_res),
    .out_status        (out_status),
    .out_busy_mismatch (out_busy_mismatch),
    .out_option_nack   (out_option_nack)
  );

  // a nonzero status only comes with the end of a transaction
  a_status_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STATUS_OK) |-> out_done_res)
    else $error("status without done");

  // a give-up releases at once and sends nothing
  a_giveup_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_RETRIES) |-> (out_wait_kind == WAIT_NONE) && !out_send_valid)
    else $error("give-up with wait or send");

  // idle send and data fields read as zero
  a_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_send_valid |-> (out_send_byte == 8'd0))
    else $error("send byte without send valid");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data_valid |-> (out_data_byte == 8'd0) && (out_data_index == 8'd0))
    else $error("data fields without data valid");

endmodule
